// ===== rtl/pqt_pkg.sv =====
// ---------------------------------------------------------------------------
// pqt_pkg - shared types and constants of the Poisson quantile table
// Item formats, fixed-point widths, command codes, controller states and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package pqt_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int IDX_W           = 10;
	localparam int MEAN_W          = 20;
	localparam int PROB_W          = 49;   // Q0.48 plus the bit for 1.0
	localparam int COUNT_W         = 8;
	localparam int SCALED_W        = 52;   // floor(p * mean / 2^16)
	localparam int HALF_W          = 24;   // low half of p for the split multiply
	localparam int PROD_W          = 45;
	localparam int STEP_W          = 6;    // divide step counter

	localparam logic [PROB_W-1:0]  PROB_ONE  = PROB_W'(1) << 48;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	localparam logic CMD_REBUILD = 1'b0;
	localparam logic CMD_READ    = 1'b1;

	typedef struct packed {
		logic                command;
		logic [MEAN_W-1:0]   mean;
		logic [PROB_W-1:0]   start_probability;
		logic [IDX_W-1:0]    index;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  count;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV,
		ST_UPD_P,
		ST_UPD_C,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;      // load a rebuild request
		logic rd_en;      // read the table for a read request
		logic rise;       // bump the event count
		logic mul_lo;
		logic mul_hi;
		logic div_step;
		logic upd_p;
		logic upd_c;
		logic write;      // store count at the current entry, advance
		logic out_read;
		logic out_build;
	} dp_cmd_t;

	typedef struct packed {
		logic below;      // cumulative sum below current threshold
		logic last;       // current entry is the last one
	} dp_status_t;

endpackage

// ===== rtl/pqt_stream_if.sv =====
// ---------------------------------------------------------------------------
// pqt_stream_if - valid/ready channel
// Carries one payload of a type given at instantiation.
// ---------------------------------------------------------------------------
interface pqt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/pqt_ctrl.sv =====
// ---------------------------------------------------------------------------
// pqt_ctrl - sequencer of the quantile table
// Accepts requests, steps the datapath through a rebuild or a read and owns
// the result valid flag.
// ---------------------------------------------------------------------------
module pqt_ctrl
	import pqt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_command,
	output logic       req_ready,
	output logic       res_valid,
	input  logic       res_ready,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || res_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (req_command == CMD_READ) ? ST_READ : ST_CMP;
				end
			end
			ST_READ:   if (out_free) state_d = ST_IDLE;
			ST_CMP:    state_d = status.below ? ST_MUL_LO : ST_WRITE;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(SCALED_W - 1)) state_d = ST_UPD_P;
			end
			ST_UPD_P:  state_d = ST_UPD_C;
			ST_UPD_C:  state_d = ST_WRITE;
			ST_WRITE:  state_d = status.last ? ST_DONE : ST_CMP;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.rd_en = req_valid && (req_command == CMD_READ);
				cmd.start = req_valid && (req_command == CMD_REBUILD);
			end
			ST_READ:   cmd.out_read  = out_free;
			ST_CMP:    cmd.rise      = status.below;
			ST_MUL_LO: cmd.mul_lo    = 1'b1;
			ST_MUL_HI: cmd.mul_hi    = 1'b1;
			ST_DIV:    cmd.div_step  = 1'b1;
			ST_UPD_P:  cmd.upd_p     = 1'b1;
			ST_UPD_C:  cmd.upd_c     = 1'b1;
			ST_WRITE:  cmd.write     = 1'b1;
			ST_DONE:   cmd.out_build = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mul_hi) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.out_read || cmd.out_build) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/pqt_dp.sv =====
// ---------------------------------------------------------------------------
// pqt_dp - datapath of the quantile table
// Table memory, probability and cumulative sum registers, shared multiplier,
// radix-2 divider by the count and the incremental threshold i*2^48/depth.
// ---------------------------------------------------------------------------
module pqt_dp
	import pqt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  in_item_t           req,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	output logic [COUNT_W-1:0] count
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int REM_W = $clog2(TABLE_DEPTH) + 2;
	localparam longint ONE_L = longint'(1) << 48;
	localparam logic [PROB_W-1:0] THR_STEP = PROB_W'(ONE_L / TABLE_DEPTH);
	localparam logic [REM_W-1:0]  THR_REM  = REM_W'(ONE_L % TABLE_DEPTH);
	localparam logic [REM_W-1:0]  DEPTH_R  = REM_W'(TABLE_DEPTH);

	logic [COUNT_W-1:0]  mem [TABLE_DEPTH];
	logic [COUNT_W-1:0]  rdata_q;
	logic                in_range_q;
	logic                built_q;

	logic [MEAN_W-1:0]   mean_q;
	logic [PROB_W-1:0]   p_q;
	logic [PROB_W-1:0]   c_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [AW-1:0]       i_q;
	logic [PROB_W-1:0]   thr_q;
	logic [REM_W-1:0]    rem_q;
	logic [SCALED_W-1:0] sc_q;
	logic [COUNT_W-1:0]  drem_q;
	logic [COUNT_W-1:0]  out_q;

	logic [AW+IDX_W-1:0] idx_ext;
	logic [AW-1:0]       rd_addr;
	logic                rd_in_range;
	logic [PROB_W-1:0]   thr_cur;
	logic [REM_W-1:0]    rem_sum;
	logic [HALF_W:0]     mul_a;
	logic [PROD_W-1:0]   prod;
	logic [COUNT_W:0]    rem_sh;
	logic [COUNT_W:0]    rem_sub;
	logic                q_bit;
	logic [PROB_W:0]     c_sum;

	assign idx_ext     = {{AW{1'b0}}, req.index};
	assign rd_addr     = idx_ext[AW-1:0];
	assign rd_in_range = {{(32-IDX_W){1'b0}}, req.index} < 32'(TABLE_DEPTH);

	// ceil of i*2^48/depth from quotient and remainder
	assign thr_cur       = thr_q + PROB_W'(rem_q != '0);
	assign status.below  = c_q < thr_cur;
	assign status.last   = (i_q == AW'(TABLE_DEPTH - 1));
	assign rem_sum       = rem_q + THR_REM;

	assign mul_a = cmd.mul_hi ? p_q[PROB_W-1:HALF_W] : {1'b0, p_q[HALF_W-1:0]};
	assign prod  = PROD_W'(mul_a) * PROD_W'(mean_q);

	assign rem_sh  = {drem_q, sc_q[SCALED_W-1]};
	assign rem_sub = rem_sh - {1'b0, cnt_q};
	assign q_bit   = rem_sh >= {1'b0, cnt_q};

	assign c_sum = {1'b0, c_q} + {1'b0, p_q};
	assign count = out_q;

	always_ff @(posedge clk) begin
		if (cmd.write) mem[i_q] <= cnt_q;
		if (cmd.rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q <= 1'b0;
		end else if (cmd.start) begin
			built_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) in_range_q <= rd_in_range;
		if (cmd.start) begin
			mean_q <= req.mean;
			p_q    <= req.start_probability[PROB_W-1] ? PROB_ONE : req.start_probability;
			c_q    <= req.start_probability[PROB_W-1] ? PROB_ONE : req.start_probability;
			cnt_q  <= '0;
			i_q    <= '0;
			thr_q  <= '0;
			rem_q  <= '0;
		end
		if (cmd.rise && cnt_q != COUNT_MAX) cnt_q <= cnt_q + COUNT_W'(1);
		if (cmd.mul_lo) sc_q <= SCALED_W'(prod >> 16);
		if (cmd.mul_hi) begin
			sc_q   <= sc_q + (SCALED_W'(prod) << 8);
			drem_q <= '0;
		end
		if (cmd.div_step) begin
			sc_q   <= {sc_q[SCALED_W-2:0], q_bit};
			drem_q <= q_bit ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
		end
		if (cmd.upd_p) begin
			p_q <= (sc_q > SCALED_W'(PROB_ONE)) ? PROB_ONE : sc_q[PROB_W-1:0];
		end
		if (cmd.upd_c) begin
			c_q <= (c_sum > {1'b0, PROB_ONE}) ? PROB_ONE : c_sum[PROB_W-1:0];
		end
		if (cmd.write) begin
			i_q <= i_q + AW'(1);
			if (rem_sum >= DEPTH_R) begin
				rem_q <= rem_sum - DEPTH_R;
				thr_q <= thr_q + THR_STEP + PROB_W'(1);
			end else begin
				rem_q <= rem_sum;
				thr_q <= thr_q + THR_STEP;
			end
		end
		if (cmd.out_read)  out_q <= (built_q && in_range_q) ? rdata_q : '0;
		if (cmd.out_build) out_q <= cnt_q;
	end

endmodule

// ===== rtl/poisson_quantile_table_core.sv =====
// ---------------------------------------------------------------------------
// poisson_quantile_table_core - tabulated Poisson inverse CDF
// Rebuilds a table of event counts for a new mean and serves single reads.
// ---------------------------------------------------------------------------
//
//   channel   dir   payload                                        handshake
//   request   in    command, mean, start_probability, index        valid/ready
//   result    out   count                                          valid/ready
//
// Read: registered table read, then the result register; the next request is
//   taken once the read is through. Rebuild: compares and writes every entry;
//   where the count rises it also runs the split multiply and the 52-step radix-2 divide by the count.
// Reset clears control only; a table never rebuilt reads as zero, so there is
//   no clearing pass.
// The result register lets the next request in while a result waits; a
//   stalled result only holds the sequencer at its final step.
//
module poisson_quantile_table_core
	import pqt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	pqt_stream_if.sink   request,
	pqt_stream_if.source result
);

	dp_cmd_t            cmd;
	dp_status_t         status;
	logic [COUNT_W-1:0] count;
	in_item_t           req;

	assign req = request.payload;

	// sequencer: request acceptance, rebuild walk, result valid
	pqt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (request.valid),
		.req_command (req.command),
		.req_ready   (request.ready),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.cmd         (cmd),
		.status      (status)
	);

	// table, arithmetic and result payload
	pqt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.count  (count)
	);

	assign result.payload = out_item_t'(count);

endmodule

// ===== bench/poisson_quantile_table_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// poisson_quantile_table_core_test - request/result check of the quantile table
// Drives rebuild and read requests through the request channel and checks
// every result count against the typed-in count of a known directed row or
// else an in-bench copy of the table, which is rebuilt the same way.
// ---------------------------------------------------------------------------
module poisson_quantile_table_core_test;
	import pqt_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;

	typedef struct {
		logic              command;
		logic [MEAN_W-1:0] mean;
		logic [PROB_W-1:0] start_probability;
		logic [IDX_W-1:0]  index;
		bit                known;     // expected count typed in below
		logic [COUNT_W-1:0] count;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pqt_stream_if #(.payload_t(in_item_t))  request ();
	pqt_stream_if #(.payload_t(out_item_t)) result ();

	poisson_quantile_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request.sink),
		.result (result.source)
	);

	always #5 clk = ~clk;

	logic [COUNT_W-1:0] quantile_copy [DEPTH];
	logic [COUNT_W-1:0] pending_counts [$];
	int mismatches = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int holdoff_cycles = 0;

	// Walk the whole table for a new mean, as the hardware does.
	function automatic logic [COUNT_W-1:0] rebuild_table(logic [MEAN_W-1:0] mean,
			logic [PROB_W-1:0] start);
		longint unsigned p, cum, thr, m, count;
		m = mean;
		p = (start > PROB_ONE) ? PROB_ONE : start;
		cum = p;
		count = 0;
		for (longint unsigned i = 0; i < DEPTH; i++) begin
			thr = ((i << 48) + DEPTH - 1) / DEPTH;
			if (cum < thr) begin
				if (count < COUNT_MAX)
					count++;
				// split multiply keeps p*mean inside 64 bits
				p = ((((p >> 24) * m) << 8) + (((p & 64'hFFFFFF) * m) >> 16)) / count;
				if (p > PROB_ONE)
					p = PROB_ONE;
				cum += p;
				if (cum > PROB_ONE)
					cum = PROB_ONE;
			end
			quantile_copy[i] = count[COUNT_W-1:0];
		end
		return quantile_copy[DEPTH-1];
	endfunction

	function automatic logic [COUNT_W-1:0] predict_count(in_item_t it);
		if (it.command == CMD_READ)
			return (it.index < DEPTH) ? quantile_copy[it.index] : '0;
		return rebuild_table(it.mean, it.start_probability);
	endfunction

	// Software side of a rebuild: e^-mean in Q0.48.
	function automatic logic [PROB_W-1:0] start_for_mean(logic [MEAN_W-1:0] mean);
		real e;
		e = $exp(-(mean / 65536.0)) * 281474976710656.0;
		return PROB_W'(longint'(e));
	endfunction

	function automatic in_item_t random_request();
		in_item_t it;
		it.command = CMD_READ;
		it.mean = MEAN_W'($urandom);
		it.start_probability = {(PROB_W-32)'($urandom), 32'($urandom)};
		it.index = IDX_W'($urandom);
		if ($urandom_range(99) < 4) begin
			it.command = CMD_REBUILD;
			// mostly a proper e^-mean, now and then raw noise or a nudged value
			case ($urandom_range(9))
				0: ;
				1: it.start_probability = start_for_mean(it.mean) ^ PROB_W'($urandom_range(255));
				default: it.start_probability = start_for_mean(it.mean);
			endcase
			// tiny start with a tiny mean walks every entry through the divider
			if (it.start_probability < 49'h100_0000_0000 && it.mean < 20'h1000)
				it.start_probability = start_for_mean(it.mean);
		end
		return it;
	endfunction

	// Drive one request at the falling edge, then wait for its acceptance.
	task automatic send_request(in_item_t it, bit known, logic [COUNT_W-1:0] typed);
		logic [COUNT_W-1:0] predicted;
		while ($urandom_range(99) < sender_idle_pct) begin
			request.valid <= 1'b0;
			@(negedge clk);
		end
		request.valid   <= 1'b1;
		request.payload <= it;
		do @(posedge clk); while (!request.ready);
		predicted = predict_count(it);
		pending_counts = {pending_counts, (known ? typed : predicted)};
		@(negedge clk);
	endtask

	task automatic idle_sender();
		request.valid <= 1'b0;
	endtask

	// Result side: random stalls, plus the long hold-off when asked.
	always @(negedge clk) begin
		if (holdoff_cycles > 0) begin
			result.ready <= 1'b0;
			holdoff_cycles <= holdoff_cycles - 1;
		end else begin
			result.ready <= !($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (result.valid && result.ready) begin
			if (pending_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: count %0d", result.payload.count);
			end else begin
				logic [COUNT_W-1:0] want;
				want = pending_counts.pop_front();
				if (result.payload.count !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("count mismatch: expected %0d, got %0d",
							want, result.payload.count);
				end
			end
		end
	end

	stim_row_t directed [$];

	initial begin
		in_item_t it;
		stim_row_t r;
		request.valid = 1'b0;
		request.payload = '0;
		result.ready = 1'b0;
		for (int i = 0; i < DEPTH; i++)
			quantile_copy[i] = '0;

		// Directed rows: fresh table, zero mean, clamped start, range extremes.
		directed = '{
			'{CMD_READ,    20'd0,       49'd0,              10'd0,    1, 8'd0},
			'{CMD_READ,    20'd0,       49'd0,              10'd1023, 1, 8'd0},
			// zero mean, zero start: count rises at every entry but the first, saturates
			'{CMD_REBUILD, 20'd0,       49'd0,              10'd0,    1, 8'd255},
			'{CMD_READ,    20'd0,       49'd0,              10'd0,    1, 8'd0},
			'{CMD_READ,    20'd0,       49'd0,              10'd1,    1, 8'd1},
			'{CMD_READ,    20'd0,       49'd0,              10'd300,  1, 8'd255},
			'{CMD_READ,    20'd0,       49'd0,              10'd1023, 1, 8'd255},
			// start above one is clamped: cumulative sum is full, nothing rises
			'{CMD_REBUILD, 20'hFFFFF,   {49{1'b1}},         10'd0,    1, 8'd0},
			'{CMD_READ,    20'd0,       49'd0,              10'd512,  1, 8'd0},
			'{CMD_REBUILD, 20'd0,       PROB_ONE,           10'd0,    1, 8'd0},
			'{CMD_REBUILD, 20'h10000,   49'd0,              10'd0,    0, 8'd0},
			'{CMD_READ,    20'd0,       49'd0,              10'd0,    0, 8'd0},
			'{CMD_READ,    20'd0,       49'd0,              10'd777,  0, 8'd0},
			'{CMD_REBUILD, 20'hFFFFF,   49'd0,              10'd0,    0, 8'd0},
			'{CMD_READ,    20'd0,       49'd0,              10'd1023, 0, 8'd0},
			'{CMD_READ,    20'd0,       49'd0,              10'd2,    0, 8'd0},
			// zero mean from a proper start of one
			'{CMD_REBUILD, 20'd0,       49'd1,              10'd0,    0, 8'd0},
			'{CMD_READ,    20'hFFFFF,   {49{1'b1}},         10'd1022, 0, 8'd0}
		};
		// proper e^-mean for mean 1.0 and the largest mean
		directed[10].start_probability = start_for_mean(20'h10000);
		directed[13].start_probability = start_for_mean(20'hFFFFF);
		directed[16].start_probability = PROB_ONE;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[k]) begin
			r = directed[k];
			it.command = r.command;
			it.mean = r.mean;
			it.start_probability = r.start_probability;
			it.index = r.index;
			send_request(it, r.known, r.count);
		end

		// Random phases: no idling, sender idle, receiver stall, both.
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct    = (phase == 1) ? 51 : (phase == 3) ? 31 : 0;
			receiver_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 31 : 0;
			for (int n = 0; n < 120; n++) begin
				if (phase == 0 && n == 40)
					holdoff_cycles = 400;  // result side blocks, the sender then waits on request ready
				if (phase == 1 && n == 60) begin
					idle_sender();
					wait (pending_counts.size() == 0);
					@(negedge clk);
				end
				send_request(random_request(), 0, '0);
			end
		end
		idle_sender();

		wait (pending_counts.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#500_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
